// ----- rtl/efr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the escaped frame receiver.
// No dependencies; every other file uses this package.
package efr_pkg;

  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hE0;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'hD0;

  // Parser phase; the unused code acts as the address phase
  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Result event codes
  typedef enum logic [KIND_W-1:0] {
    EV_DATA = 2'd0,
    EV_OK   = 2'd1,
    EV_ERR  = 2'd2
  } event_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC   = 1'b0,
    REG_ESCAPE = 1'b1
  } cfg_reg_t;

  // One result item as it moves from the parser to the output buffer
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] payload;
    logic [BYTE_W-1:0] dest;
    logic [BYTE_W-1:0] index;
  } result_t;

  // Live framing characters
  typedef struct packed {
    logic [BYTE_W-1:0] sync;
    logic [BYTE_W-1:0] escape;
  } frame_chars_t;

endpackage

// ----- rtl/efr_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: line bytes in, results out, register writes.
// Depends on efr_pkg for widths.
interface efr_in_if;
  logic                      valid;
  logic                      ready;
  logic [efr_pkg::BYTE_W-1:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

interface efr_out_if;
  logic                       valid;
  logic                       ready;
  logic [efr_pkg::KIND_W-1:0] event_kind;
  logic [efr_pkg::BYTE_W-1:0] payload_byte;
  logic [efr_pkg::BYTE_W-1:0] frame_destination;
  logic [efr_pkg::BYTE_W-1:0] payload_index;

  modport source (output valid, output event_kind, output payload_byte,
                  output frame_destination, output payload_index, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input frame_destination, input payload_index, output ready);
endinterface

interface efr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [efr_pkg::CFG_IDX_W-1:0] reg_index;
  logic [efr_pkg::BYTE_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/efr_cfg_regs.sv -----
`timescale 1ns / 1ps
// Sync and escape character registers behind the write channel.
// Depends on efr_pkg and efr_cfg_if.
module efr_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  efr_cfg_if.sink               cfg_ch,
  output efr_pkg::frame_chars_t chars
);
  import efr_pkg::*;

  logic [BYTE_W-1:0] sync_r;
  logic [BYTE_W-1:0] escape_r;
  logic              wr_en;

  // Writes are always accepted: ready is tied high
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid && cfg_ch.ready;

  // Update the addressed register on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r   <= SYNC_RESET;
      escape_r <= ESCAPE_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(cfg_ch.reg_index))
        REG_SYNC:   sync_r   <= cfg_ch.wdata;
        REG_ESCAPE: escape_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  assign chars.sync   = sync_r;
  assign chars.escape = escape_r;

endmodule

// ----- rtl/efr_parser.sv -----
`timescale 1ns / 1ps
// Input byte register plus the unescape and frame-parse step logic.
// Depends on efr_pkg; feeds efr_out_buf.
module efr_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [efr_pkg::BYTE_W-1:0] in_byte,
  input  efr_pkg::frame_chars_t     chars,
  output logic                      res_valid,
  output efr_pkg::result_t          res,
  input  logic                      res_ready
);
  import efr_pkg::*;

  logic              in_v_r;
  logic [BYTE_W-1:0] byte_r;
  logic              adv;

  phase_t            phase_r,  phase_nxt;
  logic              esc_r,    esc_nxt;
  logic [BYTE_W-1:0] sum_r,    sum_nxt;
  logic [BYTE_W-1:0] cnt_r,    cnt_nxt;
  logic [BYTE_W-1:0] len_r,    len_nxt;
  logic [BYTE_W-1:0] dest_r,   dest_nxt;

  logic              is_sync;
  logic              is_esc;
  logic [BYTE_W-1:0] b;
  logic              emit;
  result_t           res_c;

  // The held byte is processed when the output side has room
  assign adv      = in_v_r && res_ready;
  assign in_ready = !in_v_r || res_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

  // Unescape and classify the held byte
  assign is_sync = !esc_r && (byte_r == chars.sync);
  assign is_esc  = !esc_r && (byte_r == chars.escape);
  assign b       = esc_r ? byte_r + BYTE_W'(1) : byte_r;

  // Frame parse step
  always_comb begin
    phase_nxt     = phase_r;
    esc_nxt       = esc_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    dest_nxt      = dest_r;
    emit          = 1'b0;
    res_c.kind    = EV_DATA;
    res_c.payload = '0;
    res_c.dest    = dest_r;
    res_c.index   = cnt_r;

    if (is_sync) begin
      phase_nxt = PH_ADDR;
      cnt_nxt   = '0;
    end else if (is_esc) begin
      esc_nxt = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      case (phase_r)
        PH_LEN: begin
          len_nxt = b;
          sum_nxt = sum_r + b;
          cnt_nxt = '0;
          if (b == '0) begin
            // zero length cannot end: report it and resync
            phase_nxt   = PH_ADDR;
            emit        = 1'b1;
            res_c.kind  = EV_ERR;
            res_c.index = '0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          if (cnt_r == len_r - BYTE_W'(1)) begin
            // checksum byte closes the frame
            phase_nxt  = PH_ADDR;
            res_c.kind = (sum_r == b) ? EV_OK : EV_ERR;
          end else begin
            sum_nxt       = sum_r + b;
            cnt_nxt       = cnt_r + BYTE_W'(1);
            res_c.payload = b;
          end
        end
        default: begin
          // address phase, and the unused code
          dest_nxt  = b;
          sum_nxt   = b;
          cnt_nxt   = '0;
          phase_nxt = PH_LEN;
        end
      endcase
    end
  end

  // Advance parser state once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      esc_r   <= 1'b0;
      sum_r   <= '0;
      cnt_r   <= '0;
      len_r   <= '0;
      dest_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      dest_r  <= dest_nxt;
    end
  end

  assign res_valid = adv && emit;
  assign res       = res_c;

  // A data event only comes out of the data phase
  a_data_in_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == EV_DATA) |-> (phase_r == PH_DATA))
    else $error("data event outside data phase");

  // Frame end always returns to the address phase
  a_end_to_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind != EV_DATA) |=> (phase_r == PH_ADDR))
    else $error("frame end did not return to address phase");

  // A pending escape is consumed by the next processed byte
  a_escape_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && esc_r) |=> !esc_r)
    else $error("escape left pending");

endmodule

// ----- rtl/efr_out_buf.sv -----
`timescale 1ns / 1ps
// Two-entry output register with skid slot; ready toward the parser is registered.
// Depends on efr_pkg and efr_out_if.
module efr_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  efr_pkg::result_t push_data,
  output logic             can_take,
  efr_out_if.source        out_ch
);
  import efr_pkg::*;

  logic    main_v_r;
  logic    skid_v_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign can_take = !skid_v_r;
  assign pop      = main_v_r && out_ch.ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end
  end

  // Payload: refill main from skid, else from the parser
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      if (main_v_r) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

  assign out_ch.valid             = main_v_r;
  assign out_ch.event_kind        = main_r.kind;
  assign out_ch.payload_byte      = main_r.payload;
  assign out_ch.frame_destination = main_r.dest;
  assign out_ch.payload_index     = main_r.index;

  // Skid slot is never filled ahead of the main slot
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid valid without main valid");

  // Skid fills only while the main slot was stalled
  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(main_v_r && !out_ch.ready))
    else $error("skid filled without stall");

  // No push is offered while the buffer is full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push)
    else $error("push into full output buffer");

endmodule

// ----- rtl/escaped_frame_receiver.sv -----
`timescale 1ns / 1ps
// Escaped frame receiver: takes one raw line byte per transfer and delivers
// data bytes with their index and destination, plus a frame-ok or frame-error
// event at each frame end. Sync and escape characters are set through the
// configuration channel (reset 0xE0 and 0xD0); write them only while idle.
// A byte is taken every cycle when the output side keeps up: each byte is held
// in the input register, is parsed, and its result (if any) is registered in
// the output buffer, which drives out_ch.valid.
// A two-entry output buffer keeps in_ch.ready free of any combinational path
// from out_ch.ready. Sync and escape bytes, destination bytes and nonzero
// length bytes produce no result; a zero length byte produces a frame error.
// No clearing pass is needed after reset.
// Depends on efr_pkg, efr_if, efr_cfg_regs, efr_parser and efr_out_buf.
module escaped_frame_receiver (
  input  logic      clk,
  input  logic      rst_n,
  efr_in_if.sink    in_ch,
  efr_out_if.source out_ch,
  efr_cfg_if.sink   cfg_ch
);
  import efr_pkg::*;

  frame_chars_t chars;
  logic         res_valid;
  result_t      res;
  logic         can_take;

  // Framing character registers
  efr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .chars  (chars)
  );

  // Input register and parse step
  efr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.line_byte),
    .chars     (chars),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (can_take)
  );

  // Result register with skid slot
  efr_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_ch    (out_ch)
  );

endmodule
